[rtl/clrp_pkg.sv]
// Package with the shared types, result codes and constants of the register log parser.
package clrp_pkg;

    localparam int FRAME_COUNT_WIDTH_DEF = 24;
    localparam int LIMIT_W = 24;
    localparam int STAMP_W = 24;
    localparam int CYCLES_W = 32;

    localparam logic [7:0] MARK_BYTE = 8'h1A;
    localparam logic [7:0] FILL_BYTE = 8'hFF;
    localparam logic [7:0] SEL_PAL = 8'd0;
    localparam logic [7:0] SEL_ALT = 8'd1;
    localparam logic [7:0] SEL_EXPLICIT = 8'd255;
    localparam logic [CYCLES_W-1:0] CYCLES_PAL = 32'd70908;
    localparam logic [CYCLES_W-1:0] CYCLES_ALT = 32'd71680;

    localparam logic [3:0] HDR_SELECTOR = 4'd5;
    localparam logic [3:0] HDR_LAST = 4'd15;
    localparam logic [2:0] REC_LAST = 3'd4;

    typedef enum logic [2:0] {
        K_HEADER_OK  = 3'd0,
        K_WRITE      = 3'd1,
        K_FRAME_END  = 3'd2,
        K_STREAM_END = 3'd3,
        K_BAD_HEADER = 3'd4,
        K_TRUNCATED  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           reg_number;
        logic [7:0]           reg_value;
        logic [STAMP_W-1:0]   cycle_stamp;
        logic [LIMIT_W-1:0]   frame_count;
        logic [CYCLES_W-1:0]  frame_cycles;
        logic                 add_stream_end;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h45;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h53;
            3'd3:    b = 8'h47;
            default: b = MARK_BYTE;
        endcase
        return b;
    endfunction

endpackage

[rtl/chip_register_log_parser.sv]
// Top level of the sound-chip register log parser with its result queue and limit register.
// The parser takes one log byte per clock cycle while o_stall is low and shows its first
// result in the cycle after the byte is taken if the queue was empty. Results of one byte
// sit in a two-entry queue, so the input flows on while the output is stalled until it is full;
// a byte ending the stream with a record or the header gives two results. With i_stall low the
// queue drains one result per cycle, sustaining one byte per cycle if no byte gives two results.
module chip_register_log_parser import clrp_pkg::*; #(
    parameter int FRAME_COUNT_WIDTH = FRAME_COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_byte_value,
    input  logic                i_last_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LIMIT_W-1:0]  i_frame_limit,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_reg_number,
    output logic [7:0]          o_reg_value,
    output logic [STAMP_W-1:0]  o_cycle_stamp,
    output logic [LIMIT_W-1:0]  o_frame_count,
    output logic [CYCLES_W-1:0] o_frame_cycles,
    output logic                o_last
);

    logic [LIMIT_W-1:0] r_frame_limit;
    t_result            r_queue [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               r_second;
    logic               in_accept;
    logic               out_accept;
    logic               push;
    logic               pop;
    t_result            new_result;
    t_result            head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_count == 2'd2);
    assign in_accept   = i_valid && !o_stall;

    clrp_parse #(
        .FRAME_COUNT_WIDTH(FRAME_COUNT_WIDTH)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .i_frame_limit (r_frame_limit),
        .o_push        (push),
        .o_result      (new_result)
    );

    assign head       = r_queue[r_rd_ptr];
    assign out_accept = o_valid && !i_stall;
    assign pop        = out_accept && (r_second || !head.add_stream_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= '0;
            r_wr_ptr      <= 1'b0;
            r_rd_ptr      <= 1'b0;
            r_count       <= '0;
            r_second      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_frame_limit <= i_frame_limit;
            end
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
                r_second <= 1'b0;
            end else if (out_accept) begin
                r_second <= 1'b1;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= new_result;
        end
    end

    assign o_valid        = (r_count != 2'd0);
    assign o_kind         = r_second ? K_STREAM_END : head.kind;
    assign o_reg_number   = r_second ? 8'd0 : head.reg_number;
    assign o_reg_value    = r_second ? 8'd0 : head.reg_value;
    assign o_cycle_stamp  = r_second ? '0 : head.cycle_stamp;
    assign o_frame_count  = head.frame_count;
    assign o_frame_cycles = head.frame_cycles;
    assign o_last         = r_second || !head.add_stream_end;

endmodule

[rtl/clrp_parse.sv]
// Byte parser: header check, record split and frame counting for one byte per accepted cycle.
module clrp_parse import clrp_pkg::*; #(
    parameter int FRAME_COUNT_WIDTH = FRAME_COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte_value,
    input  logic               i_last_byte,
    input  logic [LIMIT_W-1:0] i_frame_limit,
    output logic               o_push,
    output t_result            o_result
);

    logic [3:0]                   r_hdr_idx, n_hdr_idx;
    logic                         r_in_records, n_in_records;
    logic [2:0]                   r_rec_idx, n_rec_idx;
    logic [7:0]                   r_rec_bytes [4];
    logic                         r_all_ones, n_all_ones;
    logic [FRAME_COUNT_WIDTH-1:0] r_frames, n_frames;
    logic [CYCLES_W-1:0]          r_flen, n_flen;
    logic                         r_finished, n_finished;
    logic                         r_magic_bad, n_magic_bad;
    logic                         r_sel_explicit, n_sel_explicit;
    logic                         limit_hit;
    logic                         push;
    t_result                      res;

    always_comb begin
        n_hdr_idx      = r_hdr_idx;
        n_in_records   = r_in_records;
        n_rec_idx      = r_rec_idx;
        n_all_ones     = r_all_ones;
        n_frames       = r_frames;
        n_flen         = r_flen;
        n_finished     = r_finished;
        n_magic_bad    = r_magic_bad;
        n_sel_explicit = r_sel_explicit;
        push           = 1'b0;
        limit_hit      = 1'b0;
        res            = '0;
        res.kind       = K_HEADER_OK;

        if (!r_finished) begin
            if (!r_in_records) begin
                if (r_hdr_idx < HDR_SELECTOR) begin
                    if (i_byte_value != magic_byte(r_hdr_idx[2:0])) begin
                        n_magic_bad = 1'b1;
                    end
                    if (i_last_byte) begin
                        push       = 1'b1;
                        res.kind   = K_TRUNCATED;
                        n_finished = 1'b1;
                    end else begin
                        n_hdr_idx = r_hdr_idx + 4'd1;
                    end
                end else if (r_hdr_idx == HDR_SELECTOR) begin
                    if (r_magic_bad || (i_byte_value != SEL_PAL && i_byte_value != SEL_ALT
                            && i_byte_value != SEL_EXPLICIT)) begin
                        push       = 1'b1;
                        res.kind   = K_BAD_HEADER;
                        n_finished = 1'b1;
                    end else begin
                        if (i_byte_value == SEL_PAL) begin
                            n_flen = CYCLES_PAL;
                        end else if (i_byte_value == SEL_ALT) begin
                            n_flen = CYCLES_ALT;
                        end else begin
                            n_flen = '0;
                        end
                        n_sel_explicit = (i_byte_value == SEL_EXPLICIT);
                        if (i_last_byte) begin
                            push       = 1'b1;
                            res.kind   = K_TRUNCATED;
                            n_finished = 1'b1;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 4'd1;
                        end
                    end
                end else if (r_hdr_idx != HDR_LAST) begin
                    if (r_sel_explicit) begin
                        case (r_hdr_idx)
                            4'd6:    n_flen[7:0]   = i_byte_value;
                            4'd7:    n_flen[15:8]  = i_byte_value;
                            4'd8:    n_flen[23:16] = i_byte_value;
                            4'd9:    n_flen[31:24] = i_byte_value;
                            default: n_flen = r_flen;
                        endcase
                    end
                    if (i_last_byte) begin
                        push       = 1'b1;
                        res.kind   = K_TRUNCATED;
                        n_finished = 1'b1;
                    end else begin
                        n_hdr_idx = r_hdr_idx + 4'd1;
                    end
                end else begin
                    push               = 1'b1;
                    res.kind           = K_HEADER_OK;
                    n_in_records       = 1'b1;
                    n_rec_idx          = '0;
                    n_all_ones         = 1'b1;
                    res.add_stream_end = i_last_byte;
                    n_finished         = i_last_byte;
                end
            end else if (r_rec_idx < REC_LAST) begin
                if (i_byte_value != FILL_BYTE) begin
                    n_all_ones = 1'b0;
                end
                n_rec_idx = r_rec_idx + 3'd1;
                if (i_last_byte) begin
                    push       = 1'b1;
                    res.kind   = K_STREAM_END;
                    n_finished = 1'b1;
                end
            end else begin
                push       = 1'b1;
                n_rec_idx  = '0;
                n_all_ones = 1'b1;
                if (r_all_ones && i_byte_value == FILL_BYTE) begin
                    if (r_frames != {FRAME_COUNT_WIDTH{1'b1}}) begin
                        n_frames = r_frames + 1'b1;
                    end
                    res.kind  = K_FRAME_END;
                    limit_hit = (i_frame_limit != '0)
                        && (32'(n_frames) >= 32'(i_frame_limit));
                end else begin
                    res.kind        = K_WRITE;
                    res.reg_number  = r_rec_bytes[0];
                    res.reg_value   = r_rec_bytes[1];
                    res.cycle_stamp = {i_byte_value, r_rec_bytes[3], r_rec_bytes[2]};
                end
                res.add_stream_end = limit_hit || i_last_byte;
                n_finished         = limit_hit || i_last_byte;
            end
        end
        res.frame_count  = LIMIT_W'(n_frames);
        res.frame_cycles = n_flen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx      <= '0;
            r_in_records   <= 1'b0;
            r_rec_idx      <= '0;
            r_all_ones     <= 1'b1;
            r_frames       <= '0;
            r_flen         <= '0;
            r_finished     <= 1'b0;
            r_magic_bad    <= 1'b0;
            r_sel_explicit <= 1'b0;
        end else if (i_accept) begin
            r_hdr_idx      <= n_hdr_idx;
            r_in_records   <= n_in_records;
            r_rec_idx      <= n_rec_idx;
            r_all_ones     <= n_all_ones;
            r_frames       <= n_frames;
            r_flen         <= n_flen;
            r_finished     <= n_finished;
            r_magic_bad    <= n_magic_bad;
            r_sel_explicit <= n_sel_explicit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !r_finished && r_in_records && r_rec_idx < REC_LAST) begin
            r_rec_bytes[r_rec_idx[1:0]] <= i_byte_value;
        end
    end

    assign o_push   = i_accept && push;
    assign o_result = res;

endmodule

[rtl/clrp_checker.sv]
// Port-level checker for the register log parser and its bind to the top level.
module clrp_checker import clrp_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [2:0]          o_kind,
    input logic [7:0]          o_reg_number,
    input logic [7:0]          o_reg_value,
    input logic [STAMP_W-1:0]  o_cycle_stamp,
    input logic [LIMIT_W-1:0]  o_frame_count,
    input logic [CYCLES_W-1:0] o_frame_cycles,
    input logic                o_last
);

    // A stalled result keeps its whole payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_frame_count)
            && $stable(o_reg_number) && $stable(o_reg_value) && $stable(o_frame_cycles)
            && $stable(o_cycle_stamp) && $stable(o_last))
        else $error("stalled result changed");

    // Results that end the stream are always the last of their byte.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == K_STREAM_END || o_kind == K_BAD_HEADER
            || o_kind == K_TRUNCATED) |-> o_last)
        else $error("stream ending result not marked last");

    // Only register writes carry register fields.
    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_WRITE |-> o_reg_number == 8'd0 && o_reg_value == 8'd0
            && o_cycle_stamp == '0)
        else $error("non-write result carries write fields");

    // The frame count never goes backward between consecutive transactions.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid && !i_stall) && o_valid
            |-> o_frame_count >= $past(o_frame_count))
        else $error("frame count decreased");

endmodule

bind chip_register_log_parser clrp_checker u_clrp_checker (.*);
